// ===== hw/rtl/bbl_pkg.sv =====
// Shared types and constants for the 3x3 box blur.
package bbl_pkg;

	localparam int PIX_W         = 16;
	localparam int COORD_W       = 10;
	localparam int DIM_W         = 11;
	localparam int LIMIT_DIM     = 1024;
	localparam int MAX_WIDTH_DEF = 1024;

	localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(3);
	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(17);
	localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(LIMIT_DIM);

	// nine-tap sum and divide by nine as multiply by reciprocal
	localparam int SUM_W      = PIX_W + 4;
	localparam int DIV9_MUL_W = 20;
	localparam int DIV9_SHIFT = 23;
	localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = DIV9_MUL_W'(932068);
	localparam int PROD_W     = SUM_W + DIV9_MUL_W;

	localparam int QDEPTH = 8;
	localparam int QPTR_W = 3;
	localparam int QCNT_W = 4;

	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		logic             frame_start;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0]   out_value;
		logic [COORD_W-1:0] out_row;
		logic [COORD_W-1:0] out_col;
		logic               run_last;
	} result_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} dims_t;

	typedef struct packed {
		logic               has_int;
		logic [PIX_W-1:0]   int_value;
		logic [COORD_W-1:0] int_row;
		logic [COORD_W-1:0] int_col;
		logic               has_bdr;
		logic [PIX_W-1:0]   bdr_value;
		logic [COORD_W-1:0] bdr_row;
		logic [COORD_W-1:0] bdr_col;
	} entry_t;

endpackage

// ===== hw/rtl/bbl_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
interface bbl_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bbl_queue.sv =====
// Short queue of classified words between the front and back parts.
module bbl_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  bbl_pkg::entry_t             wdata,
	input  logic                        pop,
	output bbl_pkg::entry_t             rdata,
	output logic                        nonempty,
	output logic [bbl_pkg::QCNT_W-1:0]  count
);

	bbl_pkg::entry_t               mem_q [bbl_pkg::QDEPTH];
	logic [bbl_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [bbl_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [bbl_pkg::QCNT_W-1:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata    = mem_q[rd_ptr_q];
	assign nonempty = (count_q != '0);
	assign count    = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != bbl_pkg::QCNT_W'(bbl_pkg::QDEPTH)))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue pop while empty");

endmodule

// ===== hw/rtl/bbl_front.sv =====
// Front part: position tracking, line stores, window, nine-tap sum and divide by nine.
module bbl_front #(
	parameter int MAX_WIDTH = bbl_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bbl_pkg::dims_t              dims,
	bbl_stream_if.sink                  pixels,
	input  logic [bbl_pkg::QCNT_W-1:0]  qcount,
	output logic                        push,
	output bbl_pkg::entry_t             entry
);

	localparam int WMAX  = (MAX_WIDTH < bbl_pkg::LIMIT_DIM) ? MAX_WIDTH : bbl_pkg::LIMIT_DIM;
	localparam int DEPTH = WMAX;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [bbl_pkg::DIM_W-1:0] WMAX_V = bbl_pkg::DIM_W'(WMAX);
	localparam int PW    = bbl_pkg::PIX_W;
	localparam int CW    = bbl_pkg::COORD_W;
	localparam int DW    = bbl_pkg::DIM_W;
	localparam int SW    = bbl_pkg::SUM_W;

	// position
	logic [CW-1:0] row_q, col_q;
	logic [DW-1:0] w_eff, h_eff;
	logic [CW-1:0] r0, c0, r_cur, c_cur;
	logic [DW-1:0] r1, c_next, r_next;
	logic          col_wrap, end_row, is_int, is_bdr;
	logic          accept;
	logic [bbl_pkg::QCNT_W:0] pending;

	// line store: upper row in high half, lower row in low half
	logic [2*PW-1:0] lstore_mem [DEPTH];
	logic [2*PW-1:0] rd_q;

	// stage 1
	logic          valid_s1;
	logic [PW-1:0] pix_s1;
	logic [CW-1:0] row_s1, col_s1;
	logic          int_s1, bdr_s1;
	logic          fwd_s1;
	logic [PW-1:0] fwd_up_s1, fwd_mid_s1;
	logic [PW-1:0] up, mid;
	logic [SW-1:0] sum;
	logic [PW-1:0] win_q [6];

	// stage 2
	logic          valid_s2;
	logic [SW-1:0] sum_s2;
	logic [PW-1:0] pix_s2;
	logic [CW-1:0] row_s2, col_s2;
	logic          int_s2, bdr_s2;

	// stage 3
	logic                        valid_s3;
	logic [bbl_pkg::PROD_W-1:0]  prod_s3;
	logic [PW-1:0]               pix_s3;
	logic [CW-1:0]               row_s3, col_s3;
	logic                        int_s3, bdr_s3;

	always_comb begin
		if (dims.width < bbl_pkg::DIM_MIN) begin
			w_eff = bbl_pkg::DIM_MIN;
		end else if (dims.width > WMAX_V) begin
			w_eff = WMAX_V;
		end else begin
			w_eff = dims.width;
		end
		if (dims.height < bbl_pkg::DIM_MIN) begin
			h_eff = bbl_pkg::DIM_MIN;
		end else if (dims.height > bbl_pkg::DIM_LIMIT) begin
			h_eff = bbl_pkg::DIM_LIMIT;
		end else begin
			h_eff = dims.height;
		end
	end

	// wrap a position left out of range by a size change, then classify
	always_comb begin
		r0       = pixels.data.frame_start ? '0 : row_q;
		c0       = pixels.data.frame_start ? '0 : col_q;
		col_wrap = ({1'b0, c0} >= w_eff);
		c_cur    = col_wrap ? '0 : c0;
		r1       = {1'b0, r0} + {{(DW-1){1'b0}}, col_wrap};
		r_cur    = (r1 >= h_eff) ? '0 : r1[CW-1:0];
		c_next   = {1'b0, c_cur} + 1'b1;
		r_next   = {1'b0, r_cur} + 1'b1;
		end_row  = (c_next >= w_eff);
		is_int   = (r_cur >= CW'(2)) && (c_cur >= CW'(2));
		is_bdr   = (r_cur == '0) || ({1'b0, r_cur} == h_eff - 1'b1)
			|| (c_cur == '0) || ({1'b0, c_cur} == w_eff - 1'b1);
	end

	// hold input unless the queue has room for every word in flight
	assign pending = {1'b0, qcount} + (bbl_pkg::QCNT_W+1)'(valid_s1)
		+ (bbl_pkg::QCNT_W+1)'(valid_s2) + (bbl_pkg::QCNT_W+1)'(valid_s3);
	assign pixels.ready = (pending < (bbl_pkg::QCNT_W+1)'(bbl_pkg::QDEPTH));
	assign accept = pixels.valid && pixels.ready;

	// stage 1: take line store data, or the previous word's write when it hit the same column
	assign up  = fwd_s1 ? fwd_up_s1  : rd_q[2*PW-1:PW];
	assign mid = fwd_s1 ? fwd_mid_s1 : rd_q[PW-1:0];
	assign sum = SW'(win_q[0]) + SW'(win_q[1]) + SW'(win_q[2])
		+ SW'(win_q[3]) + SW'(win_q[4]) + SW'(win_q[5])
		+ SW'(up) + SW'(mid) + SW'(pix_s1);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			lstore_mem[col_s1[AW-1:0]] <= {mid, pix_s1};
		end
		rd_q <= lstore_mem[c_cur[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				if (end_row) begin
					col_q <= '0;
					row_q <= (r_next >= h_eff) ? '0 : r_next[CW-1:0];
				end else begin
					col_q <= c_next[CW-1:0];
					row_q <= r_cur;
				end
			end
			// advance window: oldest column first
			if (valid_s1) begin
				win_q[0] <= win_q[3];
				win_q[1] <= win_q[4];
				win_q[2] <= win_q[5];
				win_q[3] <= up;
				win_q[4] <= mid;
				win_q[5] <= pix_s1;
			end
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= pixels.data.pixel_value;
			row_s1     <= r_cur;
			col_s1     <= c_cur;
			int_s1     <= is_int;
			bdr_s1     <= is_bdr;
			fwd_s1     <= valid_s1 && (c_cur == col_s1);
			fwd_up_s1  <= mid;
			fwd_mid_s1 <= pix_s1;
		end
		if (valid_s1) begin
			sum_s2 <= sum;
			pix_s2 <= pix_s1;
			row_s2 <= row_s1;
			col_s2 <= col_s1;
			int_s2 <= int_s1;
			bdr_s2 <= bdr_s1;
		end
		if (valid_s2) begin
			prod_s3 <= bbl_pkg::PROD_W'(sum_s2) * bbl_pkg::PROD_W'(bbl_pkg::DIV9_MUL);
			pix_s3  <= pix_s2;
			row_s3  <= row_s2;
			col_s3  <= col_s2;
			int_s3  <= int_s2;
			bdr_s3  <= bdr_s2;
		end
	end

	// drop words that give no result
	assign push = valid_s3 && (int_s3 || bdr_s3);

	always_comb begin
		entry.has_int   = int_s3;
		entry.int_value = prod_s3[bbl_pkg::DIV9_SHIFT +: PW];
		entry.int_row   = row_s3 - 1'b1;
		entry.int_col   = col_s3 - 1'b1;
		entry.has_bdr   = bdr_s3;
		entry.bdr_value = pix_s3;
		entry.bdr_row   = row_s3;
		entry.bdr_col   = col_s3;
	end

	a_fwd_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fwd_s1) |-> $past(valid_s1))
		else $error("line store bypass without a preceding write");

endmodule

// ===== hw/rtl/bbl_back.sv =====
// Back part: splits each queued word into its results behind an output register.
module bbl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  bbl_pkg::entry_t entry,
	input  logic            entry_valid,
	output logic            pop,
	bbl_stream_if.source    results
);

	logic              phase_q;
	logic              out_valid_q;
	bbl_pkg::result_t  out_q;
	bbl_pkg::result_t  res;
	logic              first, load;

	assign first = entry.has_int && !phase_q;
	assign load  = entry_valid && (!out_valid_q || results.ready);

	always_comb begin
		if (first) begin
			res.out_value = entry.int_value;
			res.out_row   = entry.int_row;
			res.out_col   = entry.int_col;
			res.run_last  = !entry.has_bdr;
		end else begin
			res.out_value = entry.bdr_value;
			res.out_row   = entry.bdr_row;
			res.out_col   = entry.bdr_col;
			res.run_last  = 1'b1;
		end
	end

	assign pop = load && res.run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || results.ready) begin
				out_valid_q <= entry_valid;
			end
			if (load) begin
				phase_q <= !res.run_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	a_phase_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (entry_valid && entry.has_int && entry.has_bdr))
		else $error("second result pending without a two-result word");

endmodule

// ===== hw/rtl/box_blur_3x3_top.sv =====
// Path: a pixel's results pass stage 1, stage 2, stage 3, the queue and the output register.
// Throughput: one pixel per cycle while the front is not paused; a pixel with two results sends them
// in turn through the single output register; the front pauses once queued and in-flight words reach 8.
// Reset clears position, window, pipeline, queue and output; width and height return to 17.
// Line stores are not cleared; an interior result reads them only after its rows are written.
module box_blur_3x3_top #(
	parameter int MAX_WIDTH = bbl_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bbl_pkg::APB_AW-1:0]  paddr,
	input  logic [bbl_pkg::APB_DW-1:0]  pwdata,
	output logic [bbl_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	bbl_stream_if.sink                  pixels,
	bbl_stream_if.source                results
);

	logic [bbl_pkg::DIM_W-1:0]     width_q, height_q;
	logic [bbl_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          wr_en;
	bbl_pkg::dims_t                dims;
	bbl_pkg::entry_t               push_entry, head_entry;
	logic                          push, pop, head_valid;
	logic [bbl_pkg::QCNT_W-1:0]    qcount;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2 +: bbl_pkg::REG_IDX_W];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bbl_pkg::DIM_RESET;
			height_q <= bbl_pkg::DIM_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				bbl_pkg::REG_WIDTH:  width_q  <= pwdata[bbl_pkg::DIM_W-1:0];
				bbl_pkg::REG_HEIGHT: height_q <= pwdata[bbl_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bbl_pkg::REG_WIDTH:  prdata = bbl_pkg::APB_DW'(width_q);
			bbl_pkg::REG_HEIGHT: prdata = bbl_pkg::APB_DW'(height_q);
			default:             prdata = '0;
		endcase
	end

	assign dims.width  = width_q;
	assign dims.height = height_q;

	bbl_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.dims   (dims),
		.pixels (pixels),
		.qcount (qcount),
		.push   (push),
		.entry  (push_entry)
	);

	bbl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (push_entry),
		.pop      (pop),
		.rdata    (head_entry),
		.nonempty (head_valid),
		.count    (qcount)
	);

	bbl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry       (head_entry),
		.entry_valid (head_valid),
		.pop         (pop),
		.results     (results)
	);

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 box blur: directed frames, then random frames and sizes.
module tb;
	import bbl_pkg::*;

	localparam int WD_LIMIT     = 4000;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_ITEMS = 280;

	typedef struct {
		pix_in_t px;
		int      n;
		result_t r0;
		result_t r1;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	bbl_stream_if #(.T(pix_in_t)) pixels_ch ();
	bbl_stream_if #(.T(result_t)) results_ch ();

	box_blur_3x3_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pixels  (pixels_ch),
		.results (results_ch)
	);

	// blur predictor state
	logic [PIX_W-1:0] upper_line [LIMIT_DIM];
	logic [PIX_W-1:0] lower_line [LIMIT_DIM];
	logic [PIX_W-1:0] win_cols [6];
	int               row_pos;
	int               col_pos;
	logic [DIM_W-1:0] width_cfg;
	logic [DIM_W-1:0] height_cfg;

	result_t  due_results [$];
	dir_row_t dir_rows [$];
	int       mismatches;
	int       src_idle_pct;
	int       snk_stall_pct;
	int       quiet_cycles;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int clamp_dim(input logic [DIM_W-1:0] v);
		int x;
		x = int'(v);
		if (x < 3)
			return 3;
		if (x > LIMIT_DIM)
			return LIMIT_DIM;
		return x;
	endfunction

	function automatic result_t mk_result(input logic [PIX_W-1:0] v, input int r, input int c,
			input logic last);
		result_t x;
		x.out_value = v;
		x.out_row   = COORD_W'(r);
		x.out_col   = COORD_W'(c);
		x.run_last  = last;
		return x;
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return PIX_W'($urandom_range(15));
			3: return PIX_W'(16'hFFFF - $urandom_range(15));
			default: return PIX_W'($urandom);
		endcase
	endfunction

	task automatic blur_step(input pix_in_t px, output result_t r0, output result_t r1,
			output int n);
		int               w;
		int               h;
		int               r;
		int               c;
		int               sum;
		int               j;
		logic [PIX_W-1:0] up;
		logic [PIX_W-1:0] mid;
		result_t          res [2];
		begin
			w = clamp_dim(width_cfg);
			h = clamp_dim(height_cfg);
			n = 0;
			res[0] = '0;
			res[1] = '0;
			if (px.frame_start) begin
				row_pos = 0;
				col_pos = 0;
			end
			// wrap a position left outside a shrunken frame
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
			if (row_pos >= h)
				row_pos = 0;
			r = row_pos;
			c = col_pos;
			up  = upper_line[c];
			mid = lower_line[c];
			upper_line[c] = mid;
			lower_line[c] = px.pixel_value;
			if (r >= 2 && c >= 2) begin
				sum = int'(up) + int'(mid) + int'(px.pixel_value);
				for (j = 0; j < 6; j++)
					sum += int'(win_cols[j]);
				res[n] = mk_result(PIX_W'(sum / 9), r - 1, c - 1, 1'b0);
				n++;
			end
			win_cols[0] = win_cols[3];
			win_cols[1] = win_cols[4];
			win_cols[2] = win_cols[5];
			win_cols[3] = up;
			win_cols[4] = mid;
			win_cols[5] = px.pixel_value;
			if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
				res[n] = mk_result(px.pixel_value, r, c, 1'b0);
				n++;
			end
			if (n > 0)
				res[n-1].run_last = 1'b1;
			r0 = res[0];
			r1 = res[1];
			col_pos = c + 1;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos = r + 1;
				if (row_pos >= h)
					row_pos = 0;
			end
		end
	endtask

	// typed_n < 0: take the predicted results, else the typed ones
	task automatic send_word(input pix_in_t w, input int typed_n, input result_t t0,
			input result_t t1);
		result_t p0;
		result_t p1;
		int      pn;
		begin
			blur_step(w, p0, p1, pn);
			if (typed_n >= 0) begin
				pn = typed_n;
				p0 = t0;
				p1 = t1;
			end
			if (pn > 0)
				due_results.push_back(p0);
			if (pn > 1)
				due_results.push_back(p1);
			while ($urandom_range(99) < src_idle_pct) begin
				pixels_ch.valid <= 1'b0;
				@(posedge clk);
			end
			pixels_ch.valid <= 1'b1;
			pixels_ch.data  <= w;
			@(posedge clk);
			while (!pixels_ch.ready)
				@(posedge clk);
		end
	endtask

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_WIDTH)
			width_cfg = value[DIM_W-1:0];
		else
			height_cfg = value[DIM_W-1:0];
		@(posedge clk);
	endtask

	// drop valid, wait for every result, then let the pipeline empty
	task automatic settle();
		pixels_ch.valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_row(input logic [PIX_W-1:0] v, input logic fs, input int n,
			input result_t r0, input result_t r1);
		dir_row_t row;
		row.px.pixel_value = v;
		row.px.frame_start = fs;
		row.n  = n;
		row.r0 = r0;
		row.r1 = r1;
		dir_rows.push_back(row);
	endtask

	task automatic walk_rows(input int lo, input int hi);
		int i;
		for (i = lo; i < hi; i++)
			send_word(dir_rows[i].px, dir_rows[i].n, dir_rows[i].r0, dir_rows[i].r1);
	endtask

	task automatic stream_pixels(input int count, input logic first_fs, input int start_mode,
			input int pause_at);
		int      i;
		pix_in_t w;
		for (i = 0; i < count; i++) begin
			if (i % 160 == 0) begin
				case ((start_mode + i / 160) % 4)
					0: begin
						src_idle_pct  = 0;
						snk_stall_pct = 0;
					end
					1: begin
						src_idle_pct  = 76;
						snk_stall_pct = 0;
					end
					2: begin
						src_idle_pct  = 0;
						snk_stall_pct = 76;
					end
					default: begin
						src_idle_pct  = 11;
						snk_stall_pct = 11;
					end
				endcase
			end
			if (i == pause_at) begin
				pixels_ch.valid <= 1'b0;
				@(posedge clk);
				while (due_results.size() != 0)
					@(posedge clk);
			end
			w.pixel_value = rand_pixel();
			if (i == 0)
				w.frame_start = first_fs;
			else if (row_pos == 0 && col_pos == 0)
				w.frame_start = 1'($urandom_range(1));
			else
				w.frame_start = ($urandom_range(99) < 2);
			send_word(w, -1, '0, '0);
		end
	endtask

	task automatic check_result(input result_t got);
		result_t e;
		if (due_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected word: value %h row %0d col %0d last %0b",
					got.out_value, got.out_row, got.out_col, got.run_last);
		end else begin
			e = due_results.pop_front();
			if (got.out_value !== e.out_value || got.out_row !== e.out_row ||
					got.out_col !== e.out_col || got.run_last !== e.run_last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("word mismatch: expected %h r%0d c%0d l%0b, got %h r%0d c%0d l%0b",
						e.out_value, e.out_row, e.out_col, e.run_last,
						got.out_value, got.out_row, got.out_col, got.run_last);
			end
		end
	endtask

	// receiver: check each accepted word, then pick the next ready
	initial begin
		results_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (results_ch.valid && results_ch.ready)
				check_result(results_ch.data);
			results_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WD_LIMIT) begin
			@(posedge clk);
			if ((pixels_ch.valid && pixels_ch.ready) || (results_ch.valid && results_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int               i;
		int               k;
		int               w0;
		int               h0;
		int               w1;
		int               h1;
		int               rows;
		int               cnt;
		int               ph;
		int               sent;
		logic [PIX_W-1:0] v;
		logic [APB_DW-1:0] wv;
		logic [APB_DW-1:0] hv;

		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		pixels_ch.valid = 1'b0;
		pixels_ch.data  = '0;
		width_cfg       = DIM_RESET;
		height_cfg      = DIM_RESET;
		for (i = 0; i < LIMIT_DIM; i++) begin
			upper_line[i] = '0;
			lower_line[i] = '0;
		end
		for (i = 0; i < 6; i++)
			win_cols[i] = '0;
		row_pos       = 0;
		col_pos       = 0;
		mismatches    = 0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;

		// after reset: 17x17, border pixels of row 0, then a frame start mid-row
		add_row(16'hFFFF, 1'b0, 1, mk_result(16'hFFFF, 0, 0, 1'b1), '0);
		add_row(16'h0000, 1'b0, 1, mk_result(16'h0000, 0, 1, 1'b1), '0);
		add_row(16'h1234, 1'b1, 1, mk_result(16'h1234, 0, 0, 1'b1), '0);
		// 3x3 frames of all ones, then all zeros reached by wrap at end of frame
		for (k = 0; k < 2; k++) begin
			v = (k == 0) ? 16'hFFFF : 16'h0000;
			add_row(v, (k == 0), 1, mk_result(v, 0, 0, 1'b1), '0);
			add_row(v, 1'b0, 1, mk_result(v, 0, 1, 1'b1), '0);
			add_row(v, 1'b0, 1, mk_result(v, 0, 2, 1'b1), '0);
			add_row(v, 1'b0, 1, mk_result(v, 1, 0, 1'b1), '0);
			add_row(v, 1'b0, 0, '0, '0);
			add_row(v, 1'b0, 1, mk_result(v, 1, 2, 1'b1), '0);
			add_row(v, 1'b0, 1, mk_result(v, 2, 0, 1'b1), '0);
			add_row(v, 1'b0, 1, mk_result(v, 2, 1, 1'b1), '0);
			add_row(v, 1'b0, 2, mk_result(v, 1, 1, 1'b0), mk_result(v, 2, 2, 1'b1));
		end
		add_row(16'h0001, 1'b1, -1, '0, '0);
		add_row(16'hA5A5, 1'b0, -1, '0, '0);
		add_row(16'h5A5A, 1'b0, -1, '0, '0);
		add_row(16'h8000, 1'b0, -1, '0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		walk_rows(0, 3);
		settle();
		reg_write(REG_WIDTH, 32'd3);
		reg_write(REG_HEIGHT, 32'd3);
		walk_rows(3, dir_rows.size());
		settle();

		// below the minimum, with noise above the register bits
		reg_write(REG_WIDTH, 32'd0);
		reg_write(REG_HEIGHT, 32'hFFFF_F802);
		stream_pixels(45, 1'b1, 1, -1);
		settle();

		// widest line: one full row and the start of the next
		reg_write(REG_WIDTH, 32'hFFFF_FFFF);
		reg_write(REG_HEIGHT, 32'd3);
		stream_pixels(LIMIT_DIM + 16, 1'b1, 0, 700);
		settle();

		// tallest frame, first rows
		reg_write(REG_WIDTH, 32'd3);
		reg_write(REG_HEIGHT, 32'(LIMIT_DIM));
		stream_pixels(60, 1'b1, 2, -1);
		settle();

		reg_write(REG_WIDTH, 32'(LIMIT_DIM + 1));
		reg_write(REG_HEIGHT, 32'h7FF);
		stream_pixels(60, 1'b1, 3, -1);
		settle();

		// shrink the frame mid-row so the held position falls outside it
		for (k = 0; k < 4; k++) begin
			w0   = $urandom_range(12, 8);
			h0   = $urandom_range(8, 5);
			rows = $urandom_range(h0 - 1, 2);
			reg_write(REG_WIDTH, 32'(w0));
			reg_write(REG_HEIGHT, 32'(h0));
			stream_pixels(rows * w0 + w0 - 1, 1'b1, k, -1);
			settle();
			w1 = $urandom_range(w0 - 1, 3);
			h1 = $urandom_range(h0, 3);
			reg_write(REG_WIDTH, 32'(w1));
			reg_write(REG_HEIGHT, 32'(h1));
			stream_pixels($urandom_range(40, 10), 1'b0, k + 1, -1);
			settle();
		end

		sent = 0;
		ph   = 0;
		while (sent < RANDOM_ITEMS) begin
			w0 = ($urandom_range(5) == 0) ? $urandom_range(64, 25) : $urandom_range(24, 3);
			h0 = $urandom_range(12, 3);
			cnt = w0 * h0 * $urandom_range(2, 1) + $urandom_range(w0);
			if (cnt > 150)
				cnt = 150;
			wv = 32'(w0);
			hv = 32'(h0);
			if ($urandom_range(7) == 0)
				wv = 32'($urandom_range(2));
			if ($urandom_range(7) == 0)
				hv = 32'($urandom_range(2));
			if ($urandom_range(1) == 1)
				wv = wv | ($urandom << DIM_W);
			if ($urandom_range(1) == 1)
				hv = hv | ($urandom << DIM_W);
			reg_write(REG_WIDTH, wv);
			reg_write(REG_HEIGHT, hv);
			stream_pixels(cnt, 1'b1, ph % 4,
				($urandom_range(2) == 0) ? int'($urandom_range(cnt - 1)) : -1);
			sent += cnt;
			settle();
			ph++;
		end

		if (mismatches == 0 && due_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
